[rtl/mre_pkg.sv]
package mre_pkg;

  localparam int unsigned SeqBytes = 17;
  localparam int unsigned SeqW     = SeqBytes * 8;

  localparam logic [13:0] CoordMax   = 14'd9999;
  localparam logic [13:0] X10Limit   = 14'd223;
  localparam logic [10:0] Utf8Max    = 11'h7FF;
  localparam logic [10:0] ByteMax    = 11'd255;
  localparam logic [7:0]  CharOffset = 8'd32;
  localparam logic [7:0]  EscByte    = 8'h1B;

  typedef enum logic [1:0] {
    ModeX10   = 2'd0,
    ModeUtf8  = 2'd1,
    ModeSgr   = 2'd2,
    ModeUrxvt = 2'd3
  } mode_e;

  // Load enables of the two register stages of the digit unit.
  typedef struct packed {
    logic a;
    logic b;
  } stage_en_t;

  // Split 0..99 into two BCD digits, tens in the upper nibble.
  function automatic logic [7:0] bcd2(logic [6:0] n);
    logic [14:0] t;
    logic [3:0]  tens;
    logic [6:0]  ones;
    t    = 15'(n) * 15'd205;
    tens = t[14:11];
    ones = n - 7'(7'(tens) * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage

[rtl/mre_digits.sv]
module mre_digits (
  input  logic               clk_i,
  input  mre_pkg::stage_en_t en_i,
  input  logic [13:0]        val_i,
  output logic [6:0]         hi_o,
  output logic [6:0]         lo_o
);
  import mre_pkg::*;

  logic [26:0] prod;
  logic [6:0]  hi_a_q;
  logic [13:0] val_a_q;
  logic [13:0] lo_full;
  logic [6:0]  hi_b_q, lo_b_q;

  // Value / 100 by reciprocal; exact for values up to 9999.
  assign prod    = 27'(val_i) * 27'd5243;
  assign lo_full = val_a_q - 14'(14'(hi_a_q) * 14'd100);

  always_ff @(posedge clk_i) begin
    if (en_i.a) begin
      hi_a_q  <= prod[25:19];
      val_a_q <= val_i;
    end
    if (en_i.b) begin
      hi_b_q <= hi_a_q;
      lo_b_q <= lo_full[6:0];
    end
  end

  assign hi_o = hi_b_q;
  assign lo_o = lo_b_q;

endmodule

[rtl/terminal_mouse_report_encoder.sv]
// Mouse report encoder: each input transaction is one mouse event and yields the
// bytes of an xterm-style report (X10, UTF-8 extended, SGR or urxvt, chosen by
// the encoding_mode register at address 0), one byte per output transaction,
// tlast on the final byte and tuser flagging an X10 event whose coordinates do
// not fit (a single zero byte). A report is 1 to 17 bytes and the output port
// drives one byte per cycle while m_axis_tready holds. A five-stage pipeline ahead
// of the output buffer keeps taking events every cycle while an earlier report
// is still draining, and stalls only when it fills.
module terminal_mouse_report_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis_tdata: button_code[7:0], column[21:8], row_index[35:22],
  //               is_press[36], modifier_bits[39:37]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  // m_axis_tdata: out_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  // m_axis_tuser: rejected[0]
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mre_pkg::*;

  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  len;
  } field_t;

  typedef struct packed {
    logic [SeqW-1:0] bytes;
    logic [4:0]      len;
  } seq_t;

  typedef struct packed {
    mode_e       mode;
    logic        press;
    logic        rej;
    logic [7:0]  cc;
    logic [10:0] xx;
    logic [10:0] yy;
  } side_t;

  function automatic seq_t append(seq_t s, field_t f);
    seq_t r;
    r.bytes = (s.bytes << {f.len, 3'b000}) | SeqW'(f.bytes);
    r.len   = s.len + 5'(f.len);
    return r;
  endfunction

  function automatic field_t one_byte(logic [7:0] b);
    field_t f;
    f.bytes = 32'(b);
    f.len   = 3'd1;
    return f;
  endfunction

  function automatic field_t dec_field(logic [6:0] hi, logic [6:0] lo);
    field_t     f;
    logic [7:0] h, l;
    h = bcd2(hi);
    l = bcd2(lo);
    f.bytes = {4'h3, h[7:4], 4'h3, h[3:0], 4'h3, l[7:4], 4'h3, l[3:0]};
    // Drop leading zeros, keep at least one digit.
    if (h[7:4] != 4'd0) begin
      f.len = 3'd4;
    end else if (h[3:0] != 4'd0) begin
      f.len   = 3'd3;
      f.bytes = {8'd0, f.bytes[23:0]};
    end else if (l[7:4] != 4'd0) begin
      f.len   = 3'd2;
      f.bytes = {16'd0, f.bytes[15:0]};
    end else begin
      f.len   = 3'd1;
      f.bytes = {24'd0, f.bytes[7:0]};
    end
    return f;
  endfunction

  function automatic field_t utf8_field(logic [10:0] v);
    field_t f;
    if (v < 11'h080) begin
      f.bytes = 32'(v[7:0]);
      f.len   = 3'd1;
    end else begin
      f.bytes = {16'd0, 3'b110, v[10:6], 2'b10, v[5:0]};
      f.len   = 3'd2;
    end
    return f;
  endfunction

  // Configuration register
  mode_e mode_q;

  assign pready = 1'b1;
  assign prdata = {30'd0, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeX10;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      mode_q <= mode_e'(pwdata[1:0]);
    end
  end

  // Pipeline control
  logic v1_q, v2_q, v3_q, v4_q, v5_q, ov_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, load_out;
  logic [4:0] idx_q;

  assign load_out = !ov_q || (m_axis_tready && idx_q == 5'd0);
  assign rdy5     = !v5_q || load_out;
  assign rdy4     = !v4_q || rdy5;
  assign rdy3     = !v3_q || rdy4;
  assign rdy2     = !v2_q || rdy3;
  assign rdy1     = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // Stage 1: capture the event
  logic [7:0]  btn_q;
  logic [13:0] col_q, row_q;
  logic        press_q;
  logic [2:0]  mods_q;
  mode_e       mode1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      btn_q   <= s_axis_tdata[7:0];
      col_q   <= s_axis_tdata[21:8];
      row_q   <= s_axis_tdata[35:22];
      press_q <= s_axis_tdata[36];
      mods_q  <= s_axis_tdata[39:37];
      mode1_q <= mode_q;
    end
  end

  // One-based coordinates, saturation, modifiers and clamps
  logic [14:0] x_inc, y_inc;
  logic [13:0] x_sat, y_sat, x_off, y_off;
  logic [7:0]  c_mod;
  logic [8:0]  c_off;
  logic [10:0] top;
  side_t       side1;

  always_comb begin
    x_inc = 15'(col_q) + 15'd1;
    y_inc = 15'(row_q) + 15'd1;
    x_sat = (x_inc > 15'(CoordMax)) ? CoordMax : x_inc[13:0];
    y_sat = (y_inc > 15'(CoordMax)) ? CoordMax : y_inc[13:0];
    c_mod = btn_q | {3'b000, mods_q, 2'b00};
    c_off = 9'(c_mod) + 9'(CharOffset);
    x_off = x_sat + 14'(CharOffset);
    y_off = y_sat + 14'(CharOffset);
    top   = (mode1_q == ModeUtf8) ? Utf8Max : ByteMax;
    side1.mode  = mode1_q;
    side1.press = press_q;
    side1.rej   = (mode1_q == ModeX10) && (x_sat > X10Limit || y_sat > X10Limit);
    side1.cc    = c_off[8] ? 8'hFF : c_off[7:0];
    side1.xx    = (x_off > 14'(top)) ? top : x_off[10:0];
    side1.yy    = (y_off > 14'(top)) ? top : y_off[10:0];
  end

  // Stages 2 and 3: decimal split runs alongside the side data
  stage_en_t dig_en;
  logic [6:0] c_hi, c_lo, x_hi, x_lo, y_hi, y_lo;
  side_t side2_q, side3_q;

  assign dig_en.a = rdy2;
  assign dig_en.b = rdy3;

  mre_digits u_dig_c (
    .clk_i (clk_i),
    .en_i  (dig_en),
    .val_i (14'(c_mod)),
    .hi_o  (c_hi),
    .lo_o  (c_lo)
  );

  mre_digits u_dig_x (
    .clk_i (clk_i),
    .en_i  (dig_en),
    .val_i (x_sat),
    .hi_o  (x_hi),
    .lo_o  (x_lo)
  );

  mre_digits u_dig_y (
    .clk_i (clk_i),
    .en_i  (dig_en),
    .val_i (y_sat),
    .hi_o  (y_hi),
    .lo_o  (y_lo)
  );

  always_ff @(posedge clk_i) begin
    if (rdy2) side2_q <= side1;
    if (rdy3) side3_q <= side2_q;
  end

  // Stage 4: per-field byte groups
  field_t dc_q, dx_q, dy_q, uc_q, ux_q, uy_q;
  side_t  side4_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      dc_q    <= dec_field(c_hi, c_lo);
      dx_q    <= dec_field(x_hi, x_lo);
      dy_q    <= dec_field(y_hi, y_lo);
      uc_q    <= utf8_field(11'(side3_q.cc));
      ux_q    <= utf8_field(side3_q.xx);
      uy_q    <= utf8_field(side3_q.yy);
      side4_q <= side3_q;
    end
  end

  // Stage 5: assemble the report, first byte at the highest occupied byte
  seq_t seq;
  seq_t seq5_q;
  logic rej5_q;

  always_comb begin
    seq = '0;
    if (side4_q.rej) begin
      seq.len = 5'd1;
    end else begin
      seq = append(seq, one_byte(EscByte));
      seq = append(seq, one_byte("["));
      case (side4_q.mode)
        ModeSgr, ModeUrxvt: begin
          if (side4_q.mode == ModeSgr) seq = append(seq, one_byte("<"));
          seq = append(seq, dc_q);
          seq = append(seq, one_byte(";"));
          seq = append(seq, dx_q);
          seq = append(seq, one_byte(";"));
          seq = append(seq, dy_q);
          seq = append(seq, one_byte((side4_q.mode == ModeUrxvt || side4_q.press)
                                     ? 8'h4D : 8'h6D));
        end
        ModeUtf8: begin
          seq = append(seq, one_byte("M"));
          seq = append(seq, uc_q);
          seq = append(seq, ux_q);
          seq = append(seq, uy_q);
        end
        default: begin
          seq = append(seq, one_byte("M"));
          seq = append(seq, one_byte(side4_q.cc));
          seq = append(seq, one_byte(side4_q.xx[7:0]));
          seq = append(seq, one_byte(side4_q.yy[7:0]));
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      seq5_q <= seq;
      rej5_q <= side4_q.rej;
    end
  end

  // Output buffer: count down from the first byte to byte zero
  logic [SeqW-1:0] buf_q;
  logic            rej_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= 5'd0;
    end else if (load_out) begin
      ov_q  <= v5_q;
      idx_q <= seq5_q.len - 5'd1;
    end else if (m_axis_tready) begin
      idx_q <= idx_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      buf_q <= seq5_q.bytes;
      rej_q <= rej5_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = buf_q[{idx_q, 3'b000} +: 8];
  assign m_axis_tlast  = (idx_q == 5'd0);
  assign m_axis_tuser  = rej_q;

endmodule

[rtl/mre_checker.sv]
module mre_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // A rejected event is a single zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'd0)
    else $error("rejected transaction is not a lone zero byte");

  // A report that starts right after the last byte of another is accepted begins with ESC unless rejected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast ##1 m_axis_tvalid && !m_axis_tuser
    |-> m_axis_tdata == 8'h1B)
    else $error("report does not start with ESC");

  // Input back-pressure only while output is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // Stalled output holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled output changed");

endmodule

bind terminal_mouse_report_encoder mre_checker u_mre_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
